// ===== rtl/assert_macros.svh =====
// assertion macros used by nand_flash_array_model
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define NFA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define NFA_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define NFA_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define NFA_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/nfa_pkg.sv =====
// types, geometry constants and codes of the nand flash array model
// no dependencies
`default_nettype none
package nfa_pkg;

    localparam int NUM_BLOCK       = 64;
    localparam int PAGES_PER_BLOCK = 64;
    localparam int DATA_WORDS      = 512;
    localparam int SPARE_WORDS     = 16;
    localparam int PAGE_WORDS      = DATA_WORDS + SPARE_WORDS;
    localparam int STORE_WORDS     = NUM_BLOCK * PAGES_PER_BLOCK * PAGE_WORDS;

    localparam int BLK_AW   = (NUM_BLOCK > 1) ? $clog2(NUM_BLOCK) : 1;
    localparam int ROW_W    = (NUM_BLOCK * PAGES_PER_BLOCK > 1) ?
                              $clog2(NUM_BLOCK * PAGES_PER_BLOCK) : 1;
    localparam int STORE_AW = (STORE_WORDS > 1) ? $clog2(STORE_WORDS) : 1;
    localparam int ROWX_W   = 14;
    localparam int ADDRX_W  = 24;
    localparam int PTR_W    = 7;

    localparam logic [1:0] OP_READ  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_ERASE = 2'd2;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_RANGE     = 2'd1;
    localparam logic [1:0] ST_UNWRITTEN = 2'd2;
    localparam logic [1:0] ST_BELOW     = 2'd3;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [6:0]  block_index;
        logic [6:0]  page_index;
        logic [9:0]  word_index;
        logic [31:0] write_word;
        logic        last_word;
    } item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] read_word;
        logic [31:0] read_pages;
        logic [31:0] written_pages;
        logic [31:0] erased_blocks;
    } result_t;

    typedef struct packed {
        logic              rd_en;
        logic [BLK_AW-1:0] rd_addr;
        logic              wr_en;
        logic [BLK_AW-1:0] wr_addr;
        logic [PTR_W-1:0]  wr_data;
    } ptr_req_t;

    typedef struct packed {
        logic                en;
        logic                we;
        logic [STORE_AW-1:0] addr;
        logic [31:0]         wdata;
    } store_req_t;

endpackage
`default_nettype wire

// ===== rtl/nfa_ptr_table.sv =====
// per-block write pointer memory, registered read, reset to zero via valid bits
// depends on nfa_pkg
`default_nettype none
module nfa_ptr_table
    import nfa_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire ptr_req_t         req,
    output logic [PTR_W-1:0]      rdata
);

    logic [PTR_W-1:0]     mem_reg [NUM_BLOCK];
    logic [PTR_W-1:0]     q_reg;
    logic [NUM_BLOCK-1:0] vld_reg;
    logic                 q_vld_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem_reg[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            q_reg <= mem_reg[req.rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg   <= '0;
            q_vld_reg <= 1'b0;
        end
        else
        begin
            if (req.wr_en)
            begin
                vld_reg[req.wr_addr] <= 1'b1;
            end
            if (req.rd_en)
            begin
                q_vld_reg <= vld_reg[req.rd_addr];
            end
        end
    end

    assign rdata = q_vld_reg ? q_reg : '0;

endmodule
`default_nettype wire

// ===== rtl/nfa_page_store.sv =====
// page word store, single port, registered read
// depends on nfa_pkg
`default_nettype none
module nfa_page_store
    import nfa_pkg::*;
(
    input  wire logic       clk,
    input  wire store_req_t req,
    output logic [31:0]     rdata
);

    logic [31:0] mem_reg [STORE_WORDS];
    logic [31:0] q_reg;

    always_ff @(posedge clk)
    begin
        if (req.en)
        begin
            if (req.we)
            begin
                mem_reg[req.addr] <= req.wdata;
            end
            else
            begin
                q_reg <= mem_reg[req.addr];
            end
        end
    end

    assign rdata = q_reg;

endmodule
`default_nettype wire

// ===== rtl/nand_flash_array_model.sv =====
// top level of the nand flash array model: sequencer, counters, result register
// depends on nfa_pkg, nfa_ptr_table, nfa_page_store, assert_macros.svh
//
//   channel   direction  handshake            payload
//   req       in         req_valid/req_stall  item_t
//   rsp       out        rsp_valid/rsp_stall  result_t
//
// an item goes through accept and pointer read, check and store access, and result
// load in that order; a stalled result delays the load
// the page store is single-ported, the pointer memory has one read and one write port; both have registered reads
// a new item is accepted while a finished result still waits in rsp
// reset clears the pointers (valid bits), counters and control; no clearing pass
`default_nettype none
`include "assert_macros.svh"
module nand_flash_array_model
    import nfa_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    req_valid,
    output logic         req_stall,
    input  wire item_t   req,
    output logic         rsp_valid,
    input  wire logic    rsp_stall,
    output result_t      rsp
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_CHECK  = 2'd1;
    localparam logic [1:0] S_FINISH = 2'd2;

    logic [1:0]        state_reg, state_next;
    item_t             item_reg;
    logic [ROW_W-1:0]  row_reg;
    logic              addr_ok_reg;
    logic              blk_ok_reg;
    logic [1:0]        status_reg, status_next;
    logic              rd_ok_reg, rd_ok_next;
    logic [31:0]       rd_cnt_reg, rd_cnt_next;
    logic [31:0]       wr_cnt_reg, wr_cnt_next;
    logic [31:0]       er_cnt_reg, er_cnt_next;
    logic              rsp_valid_reg;
    result_t           rsp_reg;

    ptr_req_t          ptr_req;
    logic [PTR_W-1:0]  ptr_rdata;
    store_req_t        store_req;
    logic [31:0]       store_rdata;

    logic              accept;
    logic              slot_free;
    logic [ROWX_W-1:0] row_wide;
    logic [ADDRX_W-1:0] addr_wide;
    logic              addr_ok;
    logic              blk_ok;

    nfa_ptr_table u_ptr (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (ptr_req),
        .rdata (ptr_rdata)
    );

    nfa_page_store u_store (
        .clk   (clk),
        .req   (store_req),
        .rdata (store_rdata)
    );

    assign req_stall = (state_reg != S_IDLE);
    assign accept    = req_valid && !req_stall;
    assign slot_free = !rsp_valid_reg || !rsp_stall;

    assign blk_ok   = ({1'b0, req.block_index} < 8'(NUM_BLOCK));
    assign addr_ok  = blk_ok && ({1'b0, req.page_index} < 8'(PAGES_PER_BLOCK))
                      && ({1'b0, req.word_index} < 11'(PAGE_WORDS));
    assign row_wide = ROWX_W'(req.block_index) * ROWX_W'(PAGES_PER_BLOCK)
                      + ROWX_W'(req.page_index);
    assign addr_wide = ADDRX_W'(row_reg) * ADDRX_W'(PAGE_WORDS)
                       + ADDRX_W'(item_reg.word_index);

    always_comb
    begin
        state_next  = state_reg;
        status_next = status_reg;
        rd_ok_next  = rd_ok_reg;
        rd_cnt_next = rd_cnt_reg;
        wr_cnt_next = wr_cnt_reg;
        er_cnt_next = er_cnt_reg;

        ptr_req         = '0;
        ptr_req.rd_addr = req.block_index[BLK_AW-1:0];
        ptr_req.wr_addr = item_reg.block_index[BLK_AW-1:0];
        store_req       = '0;
        store_req.addr  = addr_wide[STORE_AW-1:0];
        store_req.wdata = item_reg.write_word;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    ptr_req.rd_en = 1'b1;
                    state_next    = S_CHECK;
                end
            end
            S_CHECK:
            begin
                status_next = ST_OK;
                rd_ok_next  = 1'b0;
                case (item_reg.opcode)
                    OP_READ:
                    begin
                        if (!addr_ok_reg)
                        begin
                            status_next = ST_RANGE;
                        end
                        else if (item_reg.page_index >= ptr_rdata)
                        begin
                            status_next = ST_UNWRITTEN;
                        end
                        else
                        begin
                            rd_ok_next   = 1'b1;
                            store_req.en = 1'b1;
                            if (item_reg.last_word)
                            begin
                                rd_cnt_next = rd_cnt_reg + 32'd1;
                            end
                        end
                    end
                    OP_WRITE:
                    begin
                        if (!addr_ok_reg)
                        begin
                            status_next = ST_RANGE;
                        end
                        else if (item_reg.page_index < ptr_rdata)
                        begin
                            status_next = ST_BELOW;
                        end
                        else
                        begin
                            store_req.en = 1'b1;
                            store_req.we = 1'b1;
                            if (item_reg.last_word)
                            begin
                                ptr_req.wr_en   = 1'b1;
                                ptr_req.wr_data = item_reg.page_index + 7'd1;
                                wr_cnt_next     = wr_cnt_reg + 32'd1;
                            end
                        end
                    end
                    OP_ERASE:
                    begin
                        if (!blk_ok_reg)
                        begin
                            status_next = ST_RANGE;
                        end
                        else
                        begin
                            ptr_req.wr_en   = 1'b1;
                            ptr_req.wr_data = '0;
                            er_cnt_next     = er_cnt_reg + 32'd1;
                        end
                    end
                    default:
                    begin
                        status_next = ST_RANGE;
                    end
                endcase
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (slot_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rd_cnt_reg    <= '0;
            wr_cnt_reg    <= '0;
            er_cnt_reg    <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            rd_cnt_reg <= rd_cnt_next;
            wr_cnt_reg <= wr_cnt_next;
            er_cnt_reg <= er_cnt_next;
            if (state_reg == S_FINISH && slot_free)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg    <= req;
            row_reg     <= row_wide[ROW_W-1:0];
            addr_ok_reg <= addr_ok;
            blk_ok_reg  <= blk_ok;
        end
        status_reg <= status_next;
        rd_ok_reg  <= rd_ok_next;
        if (state_reg == S_FINISH && slot_free)
        begin
            rsp_reg.status        <= status_reg;
            rsp_reg.read_word     <= rd_ok_reg ? store_rdata : 32'd0;
            rsp_reg.read_pages    <= rd_cnt_reg;
            rsp_reg.written_pages <= wr_cnt_reg;
            rsp_reg.erased_blocks <= er_cnt_reg;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    `NFA_ASSERT_NXT(a_accept_check, clk, rst_n, accept, state_reg == S_CHECK)
    `NFA_ASSERT_NXT(a_check_finish, clk, rst_n, state_reg == S_CHECK, state_reg == S_FINISH)
    `NFA_ASSERT_IMP(a_store_write, clk, rst_n, store_req.en && store_req.we,
        state_reg == S_CHECK && item_reg.opcode == OP_WRITE && addr_ok_reg)
    `NFA_ASSERT_NXT(a_result_load, clk, rst_n, state_reg == S_FINISH && slot_free,
        rsp_valid && state_reg == S_IDLE)

endmodule
`default_nettype wire
